// ===== hdl/assert_macros.svh =====
// Assertion helpers for the RTL; clock and reset names are fixed.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every edge out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

`endif

// ===== hdl/tcw_pkg.sv =====
package tcw_pkg;

   // Field widths
   localparam int REQ_TYPE_W  = 2;
   localparam int CHAR_W      = 8;
   localparam int INDEX_W     = 11;
   localparam int CELL_W      = 16;
   localparam int COLOR_W     = 8;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 32;

   // Request kinds
   localparam logic [REQ_TYPE_W-1:0] REQ_PUT   = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_READ  = 2'd2;

   // Control characters and attribute after reset
   localparam logic [CHAR_W-1:0]  CH_NEWLINE  = 8'd10;
   localparam logic [CHAR_W-1:0]  CH_RETURN   = 8'd13;
   localparam logic [COLOR_W-1:0] COLOR_RESET = 8'd8;

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_DRAIN,
      ST_IDLE,
      ST_RDATA,
      ST_RESP
   } tcw_state_type;

endpackage

// ===== hdl/tcw_cell_ram.sv =====
module tcw_cell_ram #(
   parameter int DEPTH = 1600,
   parameter int WIDTH = 16,
   parameter int AW    = 11
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== hdl/text_console_writer_top.sv =====
// Text console writer: a COLUMNS x ROWS cell store (attribute byte above
// character byte) with a cursor. Put, read and unused request kinds reach
// the result through ST_RESP or ST_RDATA; the result sits in an output
// register, so the next item is taken while it waits. A newline or wrap
// past the last row scrolls the store, and a clear zeroes it: both run one
// sweep over the cell memory, one cell per cycle through its read and write
// ports. After reset a clearing pass runs before the first item is taken;
// csr writes go through at any time, csr_ready is always high.
module text_console_writer_top #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 20
) (
   input  logic                             clock,
   input  logic                             reset,
   // text_color register
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tcw_pkg::COLOR_W-1:0]      csr_wdata,
   // requests
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [tcw_pkg::REQ_TDATA_W-1:0]  req_tdata,  // char_code[7:0], cell_index[18:8]
   input  logic [tcw_pkg::REQ_TYPE_W-1:0]   req_tuser,  // req_type[1:0]
   // results
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [tcw_pkg::RSP_TDATA_W-1:0]  rsp_tdata   // cell_data[15:0], cursor_pos[26:16]
);

   import tcw_pkg::*;

   `include "assert_macros.svh"

   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int AW         = $clog2(CELL_COUNT);
   localparam int CLW        = $clog2(COLUMNS);
   localparam int RW         = $clog2(ROWS);

   localparam logic [AW-1:0]  LAST_ROW_BASE = AW'(CELL_COUNT - COLUMNS);
   localparam logic [AW-1:0]  LAST_CELL     = AW'(CELL_COUNT - 1);
   localparam logic [AW-1:0]  COL_STEP      = AW'(COLUMNS);
   localparam logic [CLW-1:0] LAST_COL      = CLW'(COLUMNS - 1);
   localparam logic [RW-1:0]  LAST_ROW      = RW'(ROWS - 1);

   // Registers
   tcw_state_type       state_ff, state_in;
   logic [AW-1:0]       sweep_ff, sweep_in;
   logic                copy_ff, copy_in;
   logic                resp_pend_ff, resp_pend_in;
   logic                p_valid_ff, p_valid_in;
   logic [AW-1:0]       p_addr_ff, p_addr_in;
   logic                p_copy_ff, p_copy_in;
   logic [CLW-1:0]      col_ff, col_in;
   logic [RW-1:0]       row_ff, row_in;
   logic [AW-1:0]       base_ff, base_in;
   logic [COLOR_W-1:0]  color_ff, color_in;
   logic                rd_ok_ff, rd_ok_in;
   logic [CELL_W-1:0]   res_data_ff, res_data_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0]   rsp_cell_ff, rsp_cell_in;
   logic [INDEX_W-1:0]  rsp_cursor_ff, rsp_cursor_in;

   // Memory port signals
   logic                ram_we;
   logic [AW-1:0]       ram_waddr;
   logic [CELL_W-1:0]   ram_wdata;
   logic [AW-1:0]       ram_raddr;
   logic [CELL_W-1:0]   ram_rdata;

   // Request fields and helpers
   logic [CHAR_W-1:0]   req_char;
   logic [INDEX_W-1:0]  req_index;
   logic                req_accept;
   logic                out_free;
   logic [AW-1:0]       cursor;
   logic                next_row;
   logic [CELL_W-1:0]   read_value;

   assign req_char   = req_tdata[CHAR_W-1:0];
   assign req_index  = req_tdata[CHAR_W+INDEX_W-1:CHAR_W];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign cursor     = base_ff + AW'(col_ff);
   assign read_value = rd_ok_ff ? ram_rdata : '0;

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - CELL_W - INDEX_W)'(0), rsp_cursor_ff, rsp_cell_ff};

   tcw_cell_ram #(
      .DEPTH (CELL_COUNT),
      .WIDTH (CELL_W),
      .AW    (AW)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Next state, memory access and cursor update
   always_comb begin
      state_in      = state_ff;
      sweep_in      = sweep_ff;
      copy_in       = copy_ff;
      resp_pend_in  = resp_pend_ff;
      p_valid_in    = 1'b0;
      p_addr_in     = p_addr_ff;
      p_copy_in     = p_copy_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      base_in       = base_ff;
      color_in      = color_ff;
      rd_ok_in      = rd_ok_ff;
      res_data_in   = res_data_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_cell_in   = rsp_cell_ff;
      rsp_cursor_in = rsp_cursor_ff;
      next_row      = 1'b0;

      // sweep write-back stage: copied cell or zero
      ram_we    = p_valid_ff;
      ram_waddr = p_addr_ff;
      ram_wdata = p_copy_ff ? ram_rdata : '0;
      ram_raddr = AW'(req_index);

      if (csr_valid) begin
         color_in = csr_wdata;
      end

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_SWEEP: begin
            p_valid_in = 1'b1;
            p_addr_in  = sweep_ff;
            p_copy_in  = copy_ff && (sweep_ff < LAST_ROW_BASE);
            ram_raddr  = p_copy_in ? (sweep_ff + COL_STEP) : sweep_ff;
            if (sweep_ff == LAST_CELL) begin
               state_in = ST_DRAIN;
            end else begin
               sweep_in = sweep_ff + AW'(1);
            end
         end
         ST_DRAIN: begin
            state_in = resp_pend_ff ? ST_RESP : ST_IDLE;
         end
         ST_IDLE: begin
            if (req_accept) begin
               res_data_in = '0;
               state_in    = ST_RESP;
               case (req_tuser)
                  REQ_PUT: begin
                     if (req_char == CH_NEWLINE) begin
                        next_row = 1'b1;
                     end else if (req_char == CH_RETURN) begin
                        col_in = '0;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = cursor;
                        ram_wdata = {color_ff, req_char};
                        if (col_ff < LAST_COL) begin
                           col_in = col_ff + CLW'(1);
                        end else begin
                           next_row = 1'b1;
                        end
                     end
                  end
                  REQ_CLEAR: begin
                     col_in       = '0;
                     row_in       = '0;
                     base_in      = '0;
                     copy_in      = 1'b0;
                     sweep_in     = '0;
                     resp_pend_in = 1'b1;
                     state_in     = ST_SWEEP;
                  end
                  REQ_READ: begin
                     rd_ok_in = (32'(req_index) < 32'(CELL_COUNT));
                     state_in = ST_RDATA;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase

               // move to the next row, scrolling from the last one
               if (next_row) begin
                  col_in = '0;
                  if (row_ff != LAST_ROW) begin
                     row_in  = row_ff + RW'(1);
                     base_in = base_ff + COL_STEP;
                  end else begin
                     copy_in      = 1'b1;
                     sweep_in     = '0;
                     resp_pend_in = 1'b1;
                     state_in     = ST_SWEEP;
                  end
               end
            end
         end
         ST_RDATA: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_cell_in   = read_value;
               rsp_cursor_in = INDEX_W'(cursor);
               state_in      = ST_IDLE;
            end else begin
               res_data_in = read_value;
               state_in    = ST_RESP;
            end
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_cell_in   = res_data_ff;
               rsp_cursor_in = INDEX_W'(cursor);
               resp_pend_in  = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_ff     <= '0;
         copy_ff      <= 1'b0;
         resp_pend_ff <= 1'b0;
         p_valid_ff   <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
         base_ff      <= '0;
         color_ff     <= COLOR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         copy_ff      <= copy_in;
         resp_pend_ff <= resp_pend_in;
         p_valid_ff   <= p_valid_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         base_ff      <= base_in;
         color_ff     <= color_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      p_addr_ff     <= p_addr_in;
      p_copy_ff     <= p_copy_in;
      rd_ok_ff      <= rd_ok_in;
      res_data_ff   <= res_data_in;
      rsp_cell_ff   <= rsp_cell_in;
      rsp_cursor_ff <= rsp_cursor_in;
   end

   // Checks
   `ASSERT_ALWAYS(a_row_base, (32'(base_ff) == 32'(row_ff) * COLUMNS) && (col_ff <= LAST_COL), "cursor row base out of step with row")
   `ASSERT_IMPLY(a_sweep_addr, p_valid_ff, 32'(p_addr_ff) < 32'(CELL_COUNT), "sweep write beyond store")
   `ASSERT_IMPLY(a_rsp_cursor, rsp_valid_ff, 32'(rsp_cursor_ff) < 32'(CELL_COUNT), "reported cursor beyond store")

endmodule
